// ----- rtl/lkp_pkg.sv -----
// Shared types, constants and lookup functions for the LED and key panel controller.
package lkp_pkg;

  localparam int DIGIT_COUNT     = 8;
  localparam int READ_WAIT_TICKS = 5;

  localparam logic [4:0] LAST_REFRESH_BYTE = 5'(1 + 2 * DIGIT_COUNT);
  localparam logic [4:0] LAST_READ_BYTE    = 5'd4;

  // item kinds
  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_INIT    = 2'd1;
  localparam logic [1:0] KIND_REFRESH = 2'd2;
  localparam logic [1:0] KIND_KEY     = 2'd3;

  // configuration register indexes
  localparam logic CFG_BRIGHTNESS = 1'b0;
  localparam logic CFG_DISPLAY_ON = 1'b1;

  // bus commands
  localparam logic [7:0] CMD_DATA_AUTO = 8'h40;
  localparam logic [7:0] CMD_ADDR_ZERO = 8'hC0;
  localparam logic [7:0] CMD_READ_KEYS = 8'h42;
  localparam logic [7:0] CMD_CTRL_BASE = 8'h80;
  localparam logic [7:0] SEG_DOT       = 8'h80;

  // sub-steps of one bit
  localparam logic [1:0] SUB_CLK_LOW = 2'd0;
  localparam logic [1:0] SUB_MID     = 2'd1;
  localparam logic [1:0] SUB_LAST    = 2'd2;

  typedef enum logic [5:0] {
    PH_IDLE     = 6'b000001,
    PH_STB_LOW  = 6'b000010,
    PH_DIR      = 6'b000100,
    PH_BIT      = 6'b001000,
    PH_STB_HIGH = 6'b010000,
    PH_WAIT     = 6'b100000
  } lkp_phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] digit_codes;
    logic [7:0]  dot_mask;
    logic [63:0] led_bytes;
    logic        data_in;
  } lkp_item_t;

  typedef struct packed {
    logic       strobe_res;
    logic       serial_clock;
    logic       data_out;
    logic       data_drive;
    logic       busy_res;
    logic [3:0] key_id;
    logic       key_valid;
  } lkp_res_t;

  function automatic logic [7:0] segment_of(input logic [7:0] code);
    logic [7:0] seg;
    case (code)
      8'h00: seg = 8'h3F;
      8'h01: seg = 8'h06;
      8'h02: seg = 8'h5B;
      8'h03: seg = 8'h4F;
      8'h04: seg = 8'h66;
      8'h05: seg = 8'h6D;
      8'h06: seg = 8'h7D;
      8'h07: seg = 8'h07;
      8'h08: seg = 8'h7F;
      8'h09: seg = 8'h6F;
      8'h0A: seg = 8'h77;
      8'h0B: seg = 8'h7C;
      8'h0C: seg = 8'h39;
      8'h0D: seg = 8'h5E;
      8'h0E: seg = 8'h79;
      8'h0F: seg = 8'h71;
      8'h5F: seg = 8'h08; // underscore
      8'h2D: seg = 8'h40; // minus
      8'h20: seg = 8'h00; // blank
      8'h47: seg = 8'h3D; // G
      8'h41: seg = 8'h77; // A
      8'h49: seg = 8'h06; // I
      8'h4E: seg = 8'h37; // N
      8'h46: seg = 8'h71; // F
      8'h55: seg = 8'h3E; // U
      8'h4C: seg = 8'h38; // L
      8'h52: seg = 8'h50; // R
      8'h45: seg = 8'h79; // E
      8'h44: seg = 8'h5E; // D
      8'h59: seg = 8'h6E; // Y
      8'h48: seg = 8'h76; // H
      8'h6F: seg = 8'h5C; // o
      8'h62: seg = 8'h7C; // b
      8'h43: seg = 8'h39; // C
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

  // later matches win, so the second byte overrides the first
  function automatic logic [3:0] decode_key(input logic [7:0] first, input logic [7:0] second);
    logic [3:0] k;
    k = 4'd0;
    case (first)
      8'h04: k = 4'd1;
      8'h02: k = 4'd2;
      8'h01: k = 4'd3;
      8'h40: k = 4'd4;
      8'h20: k = 4'd5;
      8'h10: k = 4'd6;
      default: k = 4'd0;
    endcase
    case (second)
      8'h04: k = 4'd7;
      8'h02: k = 4'd8;
      8'h01: k = 4'd9;
      default: k = k;
    endcase
    return k;
  endfunction

endpackage

// ----- rtl/lkp_in_if.sv -----
// Input channel interface: command and tick items for the panel controller.
interface lkp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [63:0] digit_codes;
  logic [7:0]  dot_mask;
  logic [63:0] led_bytes;
  logic        data_in;

  modport source (output valid, kind, digit_codes, dot_mask, led_bytes, data_in, input ready);
  modport sink   (input valid, kind, digit_codes, dot_mask, led_bytes, data_in, output ready);
endinterface

// ----- rtl/lkp_out_if.sv -----
// Result channel interface: pin levels and key status after each item.
interface lkp_out_if;
  logic       valid;
  logic       ready;
  logic       strobe_res;
  logic       serial_clock;
  logic       data_out;
  logic       data_drive;
  logic       busy_res;
  logic [3:0] key_id;
  logic       key_valid;

  modport source (output valid, strobe_res, serial_clock, data_out, data_drive, busy_res,
                  key_id, key_valid, input ready);
  modport sink   (input valid, strobe_res, serial_clock, data_out, data_drive, busy_res,
                  key_id, key_valid, output ready);
endinterface

// ----- rtl/lkp_seq.sv -----
// Pin sequencer: frame store, shift register and at most one pin step per accepted item.
module lkp_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  lkp_pkg::lkp_item_t  item,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [2:0]          cfg_data,
  output lkp_pkg::lkp_res_t   res
);

  lkp_pkg::lkp_phase_t phase_r, phase_nxt;
  logic [1:0] op_kind_r, op_kind_nxt;
  logic [1:0] sub_step_r, sub_step_nxt;
  logic [2:0] bit_index_r, bit_index_nxt;
  logic [4:0] byte_index_r, byte_index_nxt;
  logic [2:0] wait_count_r, wait_count_nxt;
  logic [7:0] shift_byte_r, shift_byte_nxt;
  logic [7:0] scan_first_r, scan_first_nxt;
  logic [7:0] scan_second_r, scan_second_nxt;
  logic [3:0] held_key_r, held_key_nxt;
  logic       stb_r, stb_nxt;
  logic       clk_pin_r, clk_pin_nxt;
  logic       dio_r, dio_nxt;
  logic       drive_r, drive_nxt;
  logic [2:0] brightness_r;
  logic       display_on_r;
  logic [7:0] frame_r [16];

  logic       start;
  logic       step;
  logic       rd;
  logic       valid_key;
  logic [7:0] send_byte;
  logic [3:0] frame_sel;
  logic [7:0] ctrl_byte;

  assign start     = accept && (item.kind != lkp_pkg::KIND_TICK) && (phase_r == lkp_pkg::PH_IDLE);
  assign step      = accept && (item.kind == lkp_pkg::KIND_TICK);
  assign rd        = (op_kind_r == lkp_pkg::KIND_KEY) && (byte_index_r != 5'd0);
  assign frame_sel = 4'(byte_index_r - 5'd2);
  assign ctrl_byte = lkp_pkg::CMD_CTRL_BASE | {4'd0, display_on_r, brightness_r};

  always_comb begin
    if (op_kind_r == lkp_pkg::KIND_INIT) begin
      send_byte = frame_r[0];
    end else if (op_kind_r == lkp_pkg::KIND_KEY) begin
      send_byte = lkp_pkg::CMD_READ_KEYS;
    end else if (byte_index_r == 5'd0) begin
      send_byte = lkp_pkg::CMD_DATA_AUTO;
    end else if (byte_index_r == 5'd1) begin
      send_byte = lkp_pkg::CMD_ADDR_ZERO;
    end else begin
      send_byte = frame_r[frame_sel];
    end
  end

  always_comb begin
    phase_nxt       = phase_r;
    op_kind_nxt     = op_kind_r;
    sub_step_nxt    = sub_step_r;
    bit_index_nxt   = bit_index_r;
    byte_index_nxt  = byte_index_r;
    wait_count_nxt  = wait_count_r;
    shift_byte_nxt  = shift_byte_r;
    scan_first_nxt  = scan_first_r;
    scan_second_nxt = scan_second_r;
    held_key_nxt    = held_key_r;
    stb_nxt         = stb_r;
    clk_pin_nxt     = clk_pin_r;
    dio_nxt         = dio_r;
    drive_nxt       = drive_r;
    valid_key       = 1'b0;

    if (start) begin
      op_kind_nxt    = item.kind;
      byte_index_nxt = 5'd0;
      bit_index_nxt  = 3'd0;
      sub_step_nxt   = lkp_pkg::SUB_CLK_LOW;
      wait_count_nxt = 3'd0;
      phase_nxt      = lkp_pkg::PH_STB_LOW;
    end else if (step) begin
      case (phase_r)
        lkp_pkg::PH_IDLE: begin
        end
        lkp_pkg::PH_STB_LOW: begin
          stb_nxt   = 1'b0;
          phase_nxt = lkp_pkg::PH_DIR;
        end
        lkp_pkg::PH_DIR: begin
          drive_nxt      = !rd;
          shift_byte_nxt = rd ? 8'd0 : send_byte;
          bit_index_nxt  = 3'd0;
          sub_step_nxt   = lkp_pkg::SUB_CLK_LOW;
          phase_nxt      = lkp_pkg::PH_BIT;
        end
        lkp_pkg::PH_BIT: begin
          case (sub_step_r)
            lkp_pkg::SUB_CLK_LOW: begin
              clk_pin_nxt = 1'b0;
            end
            lkp_pkg::SUB_MID: begin
              if (rd) begin
                clk_pin_nxt = 1'b1;
              end else begin
                dio_nxt        = shift_byte_r[0];
                shift_byte_nxt = {1'b0, shift_byte_r[7:1]};
              end
            end
            default: begin
              if (rd) begin
                shift_byte_nxt = {item.data_in, shift_byte_r[7:1]};
                clk_pin_nxt    = 1'b0;
              end else begin
                clk_pin_nxt = 1'b1;
              end
            end
          endcase
          if (sub_step_r != lkp_pkg::SUB_LAST) begin
            sub_step_nxt = sub_step_r + 2'd1;
          end else begin
            sub_step_nxt = lkp_pkg::SUB_CLK_LOW;
            if (bit_index_r != 3'd7) begin
              bit_index_nxt = bit_index_r + 3'd1;
            end else begin
              // byte finished: capture scan bytes and pick the next byte or close the frame
              bit_index_nxt = 3'd0;
              if (rd && byte_index_r == 5'd1) scan_first_nxt = shift_byte_nxt;
              if (rd && byte_index_r == 5'd2) scan_second_nxt = shift_byte_nxt;
              if (op_kind_r == lkp_pkg::KIND_INIT) begin
                phase_nxt = lkp_pkg::PH_STB_HIGH;
              end else if (op_kind_r == lkp_pkg::KIND_REFRESH) begin
                if (byte_index_r == 5'd0 || byte_index_r >= lkp_pkg::LAST_REFRESH_BYTE) begin
                  phase_nxt = lkp_pkg::PH_STB_HIGH;
                end else begin
                  byte_index_nxt = byte_index_r + 5'd1;
                  phase_nxt      = lkp_pkg::PH_DIR;
                end
              end else begin
                if (byte_index_r == 5'd0) begin
                  byte_index_nxt = 5'd1;
                  wait_count_nxt = 3'd0;
                  phase_nxt = (lkp_pkg::READ_WAIT_TICKS > 0) ? lkp_pkg::PH_WAIT
                                                             : lkp_pkg::PH_DIR;
                end else if (byte_index_r < lkp_pkg::LAST_READ_BYTE) begin
                  byte_index_nxt = byte_index_r + 5'd1;
                  phase_nxt      = lkp_pkg::PH_DIR;
                end else begin
                  phase_nxt = lkp_pkg::PH_STB_HIGH;
                end
              end
            end
          end
        end
        lkp_pkg::PH_STB_HIGH: begin
          stb_nxt = 1'b1;
          if (op_kind_r == lkp_pkg::KIND_REFRESH && byte_index_r == 5'd0) begin
            // end of the mode frame: open the address frame
            byte_index_nxt = 5'd1;
            phase_nxt      = lkp_pkg::PH_STB_LOW;
          end else begin
            phase_nxt = lkp_pkg::PH_IDLE;
            if (op_kind_r == lkp_pkg::KIND_KEY) begin
              held_key_nxt = lkp_pkg::decode_key(scan_first_r, scan_second_r);
              valid_key    = 1'b1;
            end
          end
        end
        lkp_pkg::PH_WAIT: begin
          wait_count_nxt = wait_count_r + 3'd1;
          if (wait_count_nxt >= 3'(lkp_pkg::READ_WAIT_TICKS)) phase_nxt = lkp_pkg::PH_DIR;
        end
        default: begin
          phase_nxt = lkp_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    res.strobe_res   = stb_nxt;
    res.serial_clock = clk_pin_nxt;
    res.data_out     = dio_nxt;
    res.data_drive   = drive_nxt;
    res.busy_res     = (phase_nxt != lkp_pkg::PH_IDLE);
    res.key_id       = held_key_nxt;
    res.key_valid    = valid_key;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= lkp_pkg::PH_IDLE;
      op_kind_r     <= lkp_pkg::KIND_TICK;
      sub_step_r    <= lkp_pkg::SUB_CLK_LOW;
      bit_index_r   <= 3'd0;
      byte_index_r  <= 5'd0;
      wait_count_r  <= 3'd0;
      shift_byte_r  <= 8'd0;
      scan_first_r  <= 8'd0;
      scan_second_r <= 8'd0;
      held_key_r    <= 4'd0;
      stb_r         <= 1'b1;
      clk_pin_r     <= 1'b1;
      dio_r         <= 1'b0;
      drive_r       <= 1'b1;
    end else begin
      phase_r       <= phase_nxt;
      op_kind_r     <= op_kind_nxt;
      sub_step_r    <= sub_step_nxt;
      bit_index_r   <= bit_index_nxt;
      byte_index_r  <= byte_index_nxt;
      wait_count_r  <= wait_count_nxt;
      shift_byte_r  <= shift_byte_nxt;
      scan_first_r  <= scan_first_nxt;
      scan_second_r <= scan_second_nxt;
      held_key_r    <= held_key_nxt;
      stb_r         <= stb_nxt;
      clk_pin_r     <= clk_pin_nxt;
      dio_r         <= dio_nxt;
      drive_r       <= drive_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r <= 3'd2;
      display_on_r <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_index == lkp_pkg::CFG_BRIGHTNESS) brightness_r <= cfg_data;
      if (cfg_index == lkp_pkg::CFG_DISPLAY_ON) display_on_r <= cfg_data[0];
    end
  end

  // latch the frame at start; no reset, every entry read is written first
  always_ff @(posedge clk) begin
    if (start && item.kind == lkp_pkg::KIND_INIT) begin
      frame_r[0] <= ctrl_byte;
    end
    if (start && item.kind == lkp_pkg::KIND_REFRESH) begin
      for (int i = 0; i < lkp_pkg::DIGIT_COUNT; i++) begin
        frame_r[2*i]     <= lkp_pkg::segment_of(item.digit_codes[8*i +: 8]) |
                            (item.dot_mask[i] ? lkp_pkg::SEG_DOT : 8'd0);
        frame_r[2*i + 1] <= item.led_bytes[8*i +: 8];
      end
    end
  end

  a_wait_only_in_read: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == lkp_pkg::PH_WAIT |-> op_kind_r == lkp_pkg::KIND_KEY && byte_index_r == 5'd1)
    else $error("wait phase outside key read");

  a_byte_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_index_r <= lkp_pkg::LAST_REFRESH_BYTE)
    else $error("byte index past last frame byte");

  a_key_valid_ends: assert property (@(posedge clk) disable iff (!rst_n)
    res.key_valid && accept |=> phase_r == lkp_pkg::PH_IDLE && stb_r)
    else $error("key valid without closing the frame");

endmodule

// ----- rtl/lkp_out_buf.sv -----
// Output register with skid stage for result items.
module lkp_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  lkp_pkg::lkp_res_t  push_data,
  output logic               push_ready,
  lkp_out_if.source          out_ch
);

  logic              out_valid_r;
  logic              skid_valid_r;
  lkp_pkg::lkp_res_t out_data_r;
  lkp_pkg::lkp_res_t skid_data_r;
  logic              pop;

  assign pop        = out_valid_r && out_ch.ready;
  assign push_ready = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      // output stalled: park the item
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !out_valid_r) begin
      out_data_r <= skid_valid_r ? skid_data_r : push_data;
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.strobe_res   = out_data_r.strobe_res;
  assign out_ch.serial_clock = out_data_r.serial_clock;
  assign out_ch.data_out     = out_data_r.data_out;
  assign out_ch.data_drive   = out_data_r.data_drive;
  assign out_ch.busy_res     = out_data_r.busy_res;
  assign out_ch.key_id       = out_data_r.key_id;
  assign out_ch.key_valid    = out_data_r.key_valid;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds an item while output is empty");

endmodule

// ----- rtl/led_key_panel_serial_controller_top.sv -----
// Top level of the LED and key panel serial controller.
//
//   channel  direction  handshake      payload
//   in_ch    sink       valid/ready    kind, digit_codes, dot_mask, led_bytes, data_in
//   out_ch   source     valid/ready    pin levels, busy_res, key_id, key_valid
//   cfg_*    sink       cfg_we only    cfg_index selects brightness or display_on
//
// One item per cycle while in_ch.ready is high: each accepted item makes at most one pin
// step in the sequencer and its result is registered on the same edge, in the output
// register, or in the skid stage when out_ch stalls; out_ch.valid rises the next cycle.
// in_ch.ready drops only when both stages hold items and returns after one pop.
// Synchronous active-low reset returns pins to strobe high, clock high, data driven low.
module led_key_panel_serial_controller_top (
  input  logic       clk,
  input  logic       rst_n,
  lkp_in_if.sink     in_ch,
  lkp_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [2:0] cfg_data
);

  lkp_pkg::lkp_item_t item;
  lkp_pkg::lkp_res_t  res;
  logic               accept;
  logic               buf_ready;

  assign item.kind        = in_ch.kind;
  assign item.digit_codes = in_ch.digit_codes;
  assign item.dot_mask    = in_ch.dot_mask;
  assign item.led_bytes   = in_ch.led_bytes;
  assign item.data_in     = in_ch.data_in;

  assign in_ch.ready = buf_ready;
  assign accept      = in_ch.valid && buf_ready;

  lkp_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res       (res)
  );

  lkp_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .push_data  (res),
    .push_ready (buf_ready),
    .out_ch     (out_ch)
  );

endmodule
